### hdl/tpt_pkg.sv
// tpt_pkg: shared types and codes of the tag presence table
// entry layout, status, command, outcome and answer codes, sequencer states
// no dependencies
package tpt_pkg;

	typedef enum logic [1:0] {
		ST_EMPTY   = 2'd0,
		ST_PRESENT = 2'd1,
		ST_DURESS  = 2'd2,
		ST_LOST    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_SIGHT  = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OUT_REFRESHED = 2'd0,
		OUT_ADDED     = 2'd1,
		OUT_FULL      = 2'd2,
		OUT_ZERO_TAG  = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ANS_GONE   = 2'd0,
		ANS_SEEN   = 2'd1,
		ANS_DURESS = 2'd2
	} answer_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] persist;
		status_t     status;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_WRITE = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	localparam logic [15:0] PERSIST_RESET = 16'd400;
	localparam logic [4:0]  LOST_MAX      = 5'd31;

endpackage

### hdl/tag_presence_table_top.sv
// Tag presence table. Every sighting, aging tick and query walks the table through the
// single read port of the entry ram, one entry per cycle. A tick or query writes modified
// entries back in the cycle after their read, during the scan. A sighting goes from
// acceptance to the result register through the scan, the registered read, the write of
// the refreshed or added entry and the result load. A zero-tag sighting or an unused
// command skips the scan and goes straight to the result load. One transaction is worked
// at a time; the next input is taken as soon as the result is in the output register.
// The table reads as empty after reset through per-entry valid bits, so no clearing pass
// is needed.
// depends on tpt_pkg and tpt_ram
module tag_presence_table_top #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] tag_number,
	input  logic        duress,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  sighting_outcome,
	output logic [1:0]  tag_state,
	output logic [4:0]  lost_count
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	tpt_pkg::state_t   state_q;
	logic [15:0]       persist_q;
	tpt_pkg::cmd_t     cmd_q;
	logic [15:0]       tag_q;
	logic              dur_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              rd_vld_s1;
	logic              vbit_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [TABLE_ENTRIES-1:0] vld_q;

	logic              match_q;
	logic [IDX_W-1:0]  match_idx_q;
	tpt_pkg::status_t  match_st_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;

	tpt_pkg::outcome_t res_outcome_q;
	tpt_pkg::answer_t  res_ans_q;
	logic [4:0]        res_lost_q;

	logic              out_valid_q;
	tpt_pkg::outcome_t out_outcome_q;
	tpt_pkg::answer_t  out_ans_q;
	logic [4:0]        out_lost_q;

	logic              issue;
	logic [IDX_W-1:0]  rd_addr;
	logic [tpt_pkg::ENTRY_W-1:0] rd_data;
	tpt_pkg::entry_t   ent;
	logic              tag_hit;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	tpt_pkg::entry_t   wr_data;
	logic              lost_inc;
	tpt_pkg::answer_t  ans_nxt;
	logic [4:0]        lost_nxt;
	tpt_pkg::status_t  new_st;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == tpt_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign sighting_outcome = out_outcome_q;
	assign tag_state        = out_ans_q;
	assign lost_count       = out_lost_q;

	assign issue   = (state_q == tpt_pkg::S_SCAN) && (ptr_q < CNT_W'(TABLE_ENTRIES));
	assign rd_addr = ptr_q[IDX_W-1:0];

	tpt_ram #(
		.WIDTH(tpt_pkg::ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (issue),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign ent     = vbit_s1 ? tpt_pkg::entry_t'(rd_data) : '0;
	assign tag_hit = (ent.tag == tag_q);

	always_comb begin
		if (match_q) begin
			if (dur_q || (match_st_q == tpt_pkg::ST_DURESS)) begin
				new_st = tpt_pkg::ST_DURESS;
			end else begin
				new_st = tpt_pkg::ST_PRESENT;
			end
		end else begin
			new_st = tpt_pkg::ST_PRESENT;
		end
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_s1;
		wr_data  = ent;
		lost_inc = 1'b0;
		ans_nxt  = res_ans_q;
		if (rd_vld_s1) begin
			case (cmd_q)
				tpt_pkg::CMD_TICK: begin
					if (ent.persist > 16'd1) begin
						wr_en           = 1'b1;
						wr_data.persist = ent.persist - 16'd1;
					end else if (ent.persist == 16'd1) begin
						wr_en           = 1'b1;
						wr_data.persist = '0;
						wr_data.status  = tpt_pkg::ST_LOST;
						lost_inc        = 1'b1;
					end
				end
				tpt_pkg::CMD_QUERY: begin
					if (tag_hit) begin
						if (ent.status == tpt_pkg::ST_PRESENT) begin
							ans_nxt = tpt_pkg::ANS_SEEN;
						end else if (ent.status == tpt_pkg::ST_DURESS) begin
							ans_nxt        = tpt_pkg::ANS_DURESS;
							wr_en          = 1'b1;
							wr_data.status = tpt_pkg::ST_PRESENT;
						end
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == tpt_pkg::S_WRITE) begin
			wr_en           = match_q || free_q;
			wr_addr         = match_q ? match_idx_q : free_idx_q;
			wr_data.tag     = tag_q;
			wr_data.persist = persist_q;
			wr_data.status  = new_st;
		end
	end

	assign lost_nxt = (lost_inc && (res_lost_q != tpt_pkg::LOST_MAX)) ?
		res_lost_q + 5'd1 : res_lost_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tpt_pkg::S_IDLE;
			persist_q     <= tpt_pkg::PERSIST_RESET;
			ptr_q         <= '0;
			rd_vld_s1     <= 1'b0;
			vld_q         <= '0;
			match_q       <= 1'b0;
			free_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				persist_q <= cfg_data;
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (out_valid_q && out_ready && (state_q != tpt_pkg::S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tpt_pkg::S_IDLE: begin
					if (in_valid) begin
						ptr_q   <= '0;
						match_q <= 1'b0;
						free_q  <= 1'b0;
						if ((cmd == tpt_pkg::CMD_UNUSED) ||
							((cmd == tpt_pkg::CMD_SIGHT) && (tag_number == 16'd0))) begin
							state_q <= tpt_pkg::S_FIN;
						end else begin
							state_q <= tpt_pkg::S_SCAN;
						end
					end
				end
				tpt_pkg::S_SCAN: begin
					if (rd_vld_s1 && (cmd_q == tpt_pkg::CMD_SIGHT)) begin
						if (!match_q && tag_hit && (ent.status != tpt_pkg::ST_LOST)) begin
							match_q <= 1'b1;
						end
						if (!free_q && (ent.persist == 16'd0)) begin
							free_q <= 1'b1;
						end
					end
					if (rd_vld_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= (cmd_q == tpt_pkg::CMD_SIGHT) ? tpt_pkg::S_WRITE :
							tpt_pkg::S_FIN;
					end
				end
				tpt_pkg::S_WRITE: begin
					state_q <= tpt_pkg::S_FIN;
				end
				tpt_pkg::S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= tpt_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= tpt_pkg::S_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		vbit_s1 <= vld_q[rd_addr];
		idx_s1  <= rd_addr;
		if (in_valid && in_ready) begin
			cmd_q         <= tpt_pkg::cmd_t'(cmd);
			tag_q         <= tag_number;
			dur_q         <= duress;
			res_ans_q     <= tpt_pkg::ANS_GONE;
			res_lost_q    <= '0;
			res_outcome_q <= ((cmd == tpt_pkg::CMD_SIGHT) && (tag_number == 16'd0)) ?
				tpt_pkg::OUT_ZERO_TAG : tpt_pkg::OUT_REFRESHED;
		end
		if (rd_vld_s1) begin
			res_ans_q  <= ans_nxt;
			res_lost_q <= lost_nxt;
			if ((cmd_q == tpt_pkg::CMD_SIGHT) && !match_q && tag_hit &&
				(ent.status != tpt_pkg::ST_LOST)) begin
				match_idx_q <= idx_s1;
				match_st_q  <= ent.status;
			end
			if ((cmd_q == tpt_pkg::CMD_SIGHT) && !free_q && (ent.persist == 16'd0)) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == tpt_pkg::S_WRITE) begin
			if (match_q) begin
				res_outcome_q <= tpt_pkg::OUT_REFRESHED;
			end else if (free_q) begin
				res_outcome_q <= tpt_pkg::OUT_ADDED;
			end else begin
				res_outcome_q <= tpt_pkg::OUT_FULL;
			end
		end
		if ((state_q == tpt_pkg::S_FIN) && (!out_valid_q || out_ready)) begin
			out_outcome_q <= res_outcome_q;
			out_ans_q     <= res_ans_q;
			out_lost_q    <= res_lost_q;
		end
	end

endmodule

### hdl/tpt_ram.sv
// tpt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module tpt_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/tpt_checker.sv
// tpt_checker: port-level assertions for the tag presence table, bound to the top level
// depends on tag_presence_table_top port names
module tpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  sighting_outcome,
	input logic [1:0]  tag_state,
	input logic [4:0]  lost_count
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tag_state) &&
		$stable(sighting_outcome) && $stable(lost_count))
		else $error("stalled result changed");

	// one transaction in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a query answer leaves the other fields zero
	a_query_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tag_state != 2'd0) |-> (sighting_outcome == 2'd0) &&
		(lost_count == 5'd0) && (tag_state != 2'd3))
		else $error("query answer mixed with other fields");

	// a tick count leaves the other fields zero
	a_tick_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (lost_count != 5'd0) |-> (sighting_outcome == 2'd0) &&
		(tag_state == 2'd0))
		else $error("tick count mixed with other fields");

endmodule

bind tag_presence_table_top tpt_checker u_tpt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.sighting_outcome(sighting_outcome),
	.tag_state       (tag_state),
	.lost_count      (lost_count)
);
